### sv/spsu_pkg.sv
// Shared types and constants for the servo position move supervisor.
package spsu_pkg;

    localparam int unsigned DATA_W    = 16;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0] CANON_MAX = 16'hFFFF;

    // Register reset values
    localparam logic [DATA_W-1:0] ADC_START_RST     = 16'd0;
    localparam logic [DATA_W-1:0] ADC_END_RST       = 16'd4095;
    localparam logic [DATA_W-1:0] PWM_START_RST     = 16'd0;
    localparam logic [DATA_W-1:0] PWM_END_RST       = 16'hFFFF;
    localparam logic [DATA_W-1:0] SAMPLE_PERIOD_RST = 16'd10;
    localparam logic [DATA_W-1:0] HITS_NEEDED_RST   = 16'd10;
    localparam logic [DATA_W-1:0] POS_TOL_RST       = 16'd256;
    localparam logic [DATA_W-1:0] MOVE_TIMEOUT_RST  = 16'd800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADC_START     = 3'd0,
        CFG_ADC_END       = 3'd1,
        CFG_PWM_START     = 3'd2,
        CFG_PWM_END       = 3'd3,
        CFG_SAMPLE_PERIOD = 3'd4,
        CFG_HITS_NEEDED   = 3'd5,
        CFG_POS_TOL       = 3'd6,
        CFG_MOVE_TIMEOUT  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] adc_start;
        logic [DATA_W-1:0] adc_end;
        logic [DATA_W-1:0] pwm_start;
        logic [DATA_W-1:0] pwm_end;
        logic [DATA_W-1:0] sample_period;
        logic [DATA_W-1:0] hits_needed;
        logic [DATA_W-1:0] position_tolerance;
        logic [DATA_W-1:0] move_timeout;
    } cfg_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_READY  = 2'd1,
        MODE_MOVING = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GATE,
        ST_AF_START,
        ST_AF_WAIT,
        ST_MUL,
        ST_FEEDBACK,
        ST_PF_START,
        ST_PF_WAIT,
        ST_PQ_START,
        ST_PQ_WAIT,
        ST_DUTY,
        ST_MODE,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

### sv/spsu_if.sv
// Valid/ready channel interfaces for command/sample items and status results.
interface spsu_item_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [spsu_pkg::DATA_W-1:0]  target_position;
    logic [spsu_pkg::DATA_W-1:0]  adc_sample;
    logic [spsu_pkg::TICK_W-1:0]  now_ticks;

    modport source (output valid, cmd, target_position, adc_sample, now_ticks, input ready);
    modport sink   (input valid, cmd, target_position, adc_sample, now_ticks, output ready);
endinterface

interface spsu_result_if;
    logic                         valid;
    logic                         ready;
    logic                         sampled;
    logic [spsu_pkg::DATA_W-1:0]  feedback_position;
    logic [spsu_pkg::DATA_W-1:0]  pwm_duty;
    logic                         pwm_enable;
    logic                         led_on;
    logic [1:0]                   servo_mode;

    modport source (output valid, sampled, feedback_position, pwm_duty, pwm_enable, led_on,
                    servo_mode, input ready);
    modport sink   (input valid, sampled, feedback_position, pwm_duty, pwm_enable, led_on,
                    servo_mode, output ready);
endinterface

### sv/spsu_cfg.sv
// Configuration register file with write port and reset values.
module spsu_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [spsu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spsu_pkg::DATA_W-1:0]      cfg_data,
    output spsu_pkg::cfg_t                   cfg
);

    spsu_pkg::cfg_t cfg_reg;
    spsu_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (spsu_pkg::cfg_idx_t'(cfg_index))
                spsu_pkg::CFG_ADC_START:     cfg_next.adc_start          = cfg_data;
                spsu_pkg::CFG_ADC_END:       cfg_next.adc_end            = cfg_data;
                spsu_pkg::CFG_PWM_START:     cfg_next.pwm_start          = cfg_data;
                spsu_pkg::CFG_PWM_END:       cfg_next.pwm_end            = cfg_data;
                spsu_pkg::CFG_SAMPLE_PERIOD: cfg_next.sample_period      = cfg_data;
                spsu_pkg::CFG_HITS_NEEDED:   cfg_next.hits_needed        = cfg_data;
                spsu_pkg::CFG_POS_TOL:       cfg_next.position_tolerance = cfg_data;
                spsu_pkg::CFG_MOVE_TIMEOUT:  cfg_next.move_timeout       = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{spsu_pkg::ADC_START_RST, spsu_pkg::ADC_END_RST,
                         spsu_pkg::PWM_START_RST, spsu_pkg::PWM_END_RST,
                         spsu_pkg::SAMPLE_PERIOD_RST, spsu_pkg::HITS_NEEDED_RST,
                         spsu_pkg::POS_TOL_RST, spsu_pkg::MOVE_TIMEOUT_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/spsu_div.sv
// Shared restoring divider, one quotient bit per cycle.
module spsu_div (
    input  logic                clk,
    input  logic                rst_n,
    input  spsu_pkg::div_req_t  req,
    output spsu_pkg::div_rsp_t  rsp
);

    localparam int unsigned W     = spsu_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;

    logic [W:0]       trial;
    logic [W:0]       trial_diff;
    logic             fits;

    // Shift next dividend bit into the partial remainder, subtract if it fits
    assign trial      = {rem_reg, quo_reg[W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign fits       = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### sv/servo_position_move_supervisor_unit.sv
// Servo position move supervisor: sequencer around one shared serial divider.
// A set-target transaction goes straight to the finish step; a sample that fails the period
// gate is answered after the gate step, a passed sample after one division by the 16-step
// divider, and a sample that starts a new move after two more divisions (none when the PWM
// references are equal). One transaction at a time; a result left unread stalls the final step.
// Reset (rst_n, async, active low): mode READY, architectural state zero, registers to defaults.
module servo_position_move_supervisor_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    spsu_item_if.sink                        item,
    spsu_result_if.source                    result,
    input  logic                             cfg_we,
    input  logic [spsu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spsu_pkg::DATA_W-1:0]      cfg_data
);

    localparam int unsigned W  = spsu_pkg::DATA_W;
    localparam int unsigned TW = spsu_pkg::TICK_W;

    spsu_pkg::cfg_t      cfg;
    spsu_pkg::div_req_t  div_req;
    spsu_pkg::div_rsp_t  div_rsp;

    // Sequencer and architectural state
    spsu_pkg::seq_state_t state_reg, state_next;
    spsu_pkg::mode_t      mode_reg, mode_next;
    logic [W-1:0]         target_reg, target_next;
    logic [W-1:0]         last_target_reg, last_target_next;
    logic [W-1:0]         feedback_reg, feedback_next;
    logic [TW-1:0]        last_tick_reg, last_tick_next;
    logic [TW-1:0]        cmd_tick_reg, cmd_tick_next;
    logic [W-1:0]         hit_reg, hit_next;
    logic [W-1:0]         duty_reg, duty_next;
    logic                 enable_reg, enable_next;
    logic                 led_reg, led_next;
    logic                 out_valid_reg, out_valid_next;

    // Working registers for the transaction in flight
    logic [W-1:0]         adc_reg, adc_next;
    logic [TW-1:0]        now_reg, now_next;
    logic                 sampled_reg, sampled_next;
    logic [W-1:0]         prod_reg, prod_next;

    // Output holding register
    logic                 out_sampled_reg, out_sampled_next;
    logic [W-1:0]         out_feedback_reg, out_feedback_next;
    logic [W-1:0]         out_duty_reg, out_duty_next;
    logic                 out_enable_reg, out_enable_next;
    logic                 out_led_reg, out_led_next;
    spsu_pkg::mode_t      out_mode_reg, out_mode_next;

    logic                 out_free;

    spsu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spsu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    //------------------------------------------------------------------
    // Reference range decode. A reversed range (end below start) maps
    // canonical 0 to the upper reference and counts down.
    //------------------------------------------------------------------
    logic         adc_rev, adc_eq;
    logic [W-1:0] adc_span;
    logic         pwm_rev, pwm_eq;
    logic [W-1:0] pwm_span;

    assign adc_rev  = (cfg.adc_end < cfg.adc_start);
    assign adc_eq   = (cfg.adc_end == cfg.adc_start);
    assign adc_span = adc_rev ? (cfg.adc_start - cfg.adc_end) : (cfg.adc_end - cfg.adc_start);
    assign pwm_rev  = (cfg.pwm_end < cfg.pwm_start);
    assign pwm_eq   = (cfg.pwm_end == cfg.pwm_start);
    assign pwm_span = pwm_rev ? (cfg.pwm_start - cfg.pwm_end) : (cfg.pwm_end - cfg.pwm_start);

    //------------------------------------------------------------------
    // Divider requests. Three divisions share one unit:
    //   ADC factor    = 65535 / adc span
    //   PWM factor    = 65535 / pwm span
    //   PWM quotient  = position (mirrored if reversed) / PWM factor
    // The PWM factor is still held on the divider output when the
    // quotient division is launched, so it feeds the divisor directly.
    //------------------------------------------------------------------
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = spsu_pkg::CANON_MAX;
        div_req.divisor  = adc_span;
        unique case (state_reg)
            spsu_pkg::ST_AF_START:
            begin
                div_req.start = 1'b1;
            end
            spsu_pkg::ST_PF_START:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = pwm_span;
            end
            spsu_pkg::ST_PQ_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = pwm_rev ? (spsu_pkg::CANON_MAX - target_reg) : target_reg;
                div_req.divisor  = div_rsp.quotient;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Per-step arithmetic
    //------------------------------------------------------------------
    // Period gate: wrapping tick difference against the minimum period
    logic [TW-1:0] tick_diff;
    logic          gate_pass;
    assign tick_diff = now_reg - last_tick_reg;
    assign gate_pass = (tick_diff >= {{(TW-W){1'b0}}, cfg.sample_period});

    // ADC offset times factor; inside the clamp window the product stays below 65536
    logic [W-1:0]   mul_off;
    logic [2*W-1:0] mul_full;
    assign mul_off  = adc_rev ? (adc_reg - cfg.adc_end) : (adc_reg - cfg.adc_start);
    assign mul_full = mul_off * div_rsp.quotient;

    // Clamped canonical position
    logic [W-1:0] canon;
    always_comb
    begin
        if (adc_eq)
        begin
            canon = spsu_pkg::CANON_MAX;
        end
        else if (adc_rev)
        begin
            if (adc_reg <= cfg.adc_end)
                canon = spsu_pkg::CANON_MAX;
            else if (adc_reg >= cfg.adc_start)
                canon = '0;
            else
                canon = spsu_pkg::CANON_MAX - prod_reg;
        end
        else
        begin
            if (adc_reg <= cfg.adc_start)
                canon = '0;
            else if (adc_reg >= cfg.adc_end)
                canon = spsu_pkg::CANON_MAX;
            else
                canon = prod_reg;
        end
    end

    // Duty = quotient + near reference, clamped at the far reference
    logic [W:0]   duty_sum;
    logic [W-1:0] duty_far;
    logic [W-1:0] duty_calc;
    assign duty_sum = {1'b0, div_rsp.quotient} + {1'b0, (pwm_rev ? cfg.pwm_end : cfg.pwm_start)};
    assign duty_far = pwm_rev ? cfg.pwm_start : cfg.pwm_end;
    always_comb
    begin
        if (pwm_eq)
            duty_calc = cfg.pwm_end;
        else if (duty_sum > {1'b0, duty_far})
            duty_calc = duty_far;
        else
            duty_calc = duty_sum[W-1:0];
    end

    // Tolerance test, saturating hit count, end-of-move check
    logic [W-1:0]  dev;
    logic          hit_ok;
    logic [W-1:0]  hit_inc;
    logic [TW-1:0] move_age;
    logic          move_end;
    assign dev      = (target_reg < feedback_reg) ? (feedback_reg - target_reg)
                                                  : (target_reg - feedback_reg);
    assign hit_ok   = (dev <= cfg.position_tolerance) && (hit_reg != spsu_pkg::CANON_MAX);
    assign hit_inc  = hit_ok ? (hit_reg + 1'b1) : hit_reg;
    assign move_age = now_reg - cmd_tick_reg;
    assign move_end = (hit_inc >= cfg.hits_needed) ||
                      (move_age > {{(TW-W){1'b0}}, cfg.move_timeout});

    // Output register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || result.ready;

    //------------------------------------------------------------------
    // Next state
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spsu_pkg::ST_IDLE:
            begin
                if (item.valid)
                    state_next = item.cmd ? spsu_pkg::ST_GATE : spsu_pkg::ST_FINISH;
            end
            spsu_pkg::ST_GATE:
            begin
                state_next = gate_pass ? spsu_pkg::ST_AF_START : spsu_pkg::ST_FINISH;
            end
            spsu_pkg::ST_AF_START:
            begin
                state_next = spsu_pkg::ST_AF_WAIT;
            end
            spsu_pkg::ST_AF_WAIT:
            begin
                if (div_rsp.done)
                    state_next = spsu_pkg::ST_MUL;
            end
            spsu_pkg::ST_MUL:
            begin
                state_next = spsu_pkg::ST_FEEDBACK;
            end
            spsu_pkg::ST_FEEDBACK:
            begin
                // New target: equal PWM references need no division
                if (target_reg != last_target_reg)
                    state_next = pwm_eq ? spsu_pkg::ST_DUTY : spsu_pkg::ST_PF_START;
                else
                    state_next = spsu_pkg::ST_MODE;
            end
            spsu_pkg::ST_PF_START:
            begin
                state_next = spsu_pkg::ST_PF_WAIT;
            end
            spsu_pkg::ST_PF_WAIT:
            begin
                if (div_rsp.done)
                    state_next = spsu_pkg::ST_PQ_START;
            end
            spsu_pkg::ST_PQ_START:
            begin
                state_next = spsu_pkg::ST_PQ_WAIT;
            end
            spsu_pkg::ST_PQ_WAIT:
            begin
                if (div_rsp.done)
                    state_next = spsu_pkg::ST_DUTY;
            end
            spsu_pkg::ST_DUTY:
            begin
                state_next = spsu_pkg::ST_MODE;
            end
            spsu_pkg::ST_MODE:
            begin
                state_next = spsu_pkg::ST_FINISH;
            end
            spsu_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = spsu_pkg::ST_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // State and datapath updates
    //------------------------------------------------------------------
    always_comb
    begin
        mode_next         = mode_reg;
        target_next       = target_reg;
        last_target_next  = last_target_reg;
        feedback_next     = feedback_reg;
        last_tick_next    = last_tick_reg;
        cmd_tick_next     = cmd_tick_reg;
        hit_next          = hit_reg;
        duty_next         = duty_reg;
        enable_next       = enable_reg;
        led_next          = led_reg;
        adc_next          = adc_reg;
        now_next          = now_reg;
        sampled_next      = sampled_reg;
        prod_next         = prod_reg;
        out_sampled_next  = out_sampled_reg;
        out_feedback_next = out_feedback_reg;
        out_duty_next     = out_duty_reg;
        out_enable_next   = out_enable_reg;
        out_led_next      = out_led_reg;
        out_mode_next     = out_mode_reg;
        out_valid_next    = out_valid_reg && !result.ready;

        unique case (state_reg)
            spsu_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    sampled_next = 1'b0;
                    // Set-target only stores the target; the move starts at the next sample that passes the period gate
                    if (!item.cmd)
                        target_next = item.target_position;
                    adc_next = item.adc_sample;
                    now_next = item.now_ticks;
                end
            end
            spsu_pkg::ST_GATE:
            begin
                if (gate_pass)
                begin
                    last_tick_next = now_reg;
                    sampled_next   = 1'b1;
                end
            end
            spsu_pkg::ST_MUL:
            begin
                prod_next = mul_full[W-1:0];
            end
            spsu_pkg::ST_FEEDBACK:
            begin
                feedback_next = canon;
            end
            spsu_pkg::ST_DUTY:
            begin
                duty_next        = duty_calc;
                enable_next      = 1'b1;
                led_next         = 1'b1;
                last_target_next = target_reg;
                hit_next         = '0;
                cmd_tick_next    = now_reg;
                mode_next        = spsu_pkg::MODE_MOVING;
            end
            spsu_pkg::ST_MODE:
            begin
                if (mode_reg == spsu_pkg::MODE_READY)
                begin
                    duty_next = '0;
                    led_next  = 1'b0;
                end
                else if (mode_reg == spsu_pkg::MODE_MOVING)
                begin
                    // A miss keeps the count; LED stays lit after the move ends
                    hit_next = hit_inc;
                    if (move_end)
                        mode_next = spsu_pkg::MODE_IDLE;
                end
            end
            spsu_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_sampled_next  = sampled_reg;
                    out_feedback_next = feedback_reg;
                    out_duty_next     = duty_reg;
                    out_enable_next   = enable_reg;
                    out_led_next      = led_reg;
                    out_mode_next     = mode_reg;
                end
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= spsu_pkg::ST_IDLE;
            mode_reg        <= spsu_pkg::MODE_READY;
            target_reg      <= '0;
            last_target_reg <= '0;
            feedback_reg    <= '0;
            last_tick_reg   <= '0;
            cmd_tick_reg    <= '0;
            hit_reg         <= '0;
            duty_reg        <= '0;
            enable_reg      <= 1'b0;
            led_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            target_reg      <= target_next;
            last_target_reg <= last_target_next;
            feedback_reg    <= feedback_next;
            last_tick_reg   <= last_tick_next;
            cmd_tick_reg    <= cmd_tick_next;
            hit_reg         <= hit_next;
            duty_reg        <= duty_next;
            enable_reg      <= enable_next;
            led_reg         <= led_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adc_reg          <= adc_next;
        now_reg          <= now_next;
        sampled_reg      <= sampled_next;
        prod_reg         <= prod_next;
        out_sampled_reg  <= out_sampled_next;
        out_feedback_reg <= out_feedback_next;
        out_duty_reg     <= out_duty_next;
        out_enable_reg   <= out_enable_next;
        out_led_reg      <= out_led_next;
        out_mode_reg     <= out_mode_next;
    end

    //------------------------------------------------------------------
    // Channel outputs
    //------------------------------------------------------------------
    assign item.ready               = (state_reg == spsu_pkg::ST_IDLE);
    assign result.valid             = out_valid_reg;
    assign result.sampled           = out_sampled_reg;
    assign result.feedback_position = out_feedback_reg;
    assign result.pwm_duty          = out_duty_reg;
    assign result.pwm_enable        = out_enable_reg;
    assign result.led_on            = out_led_reg;
    assign result.servo_mode        = out_mode_reg;

endmodule

### test/servo_position_move_supervisor_unit_test.sv
// Self-checking testbench for the servo position move supervisor unit.
module servo_position_move_supervisor_unit_test;

    import spsu_pkg::*;

    // Item kinds carried in the cmd field
    localparam logic CMD_SET_TARGET = 1'b0;
    localparam logic CMD_SAMPLE     = 1'b1;

    // Run length guard, in clock cycles
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          PHASES      = 14;
    localparam int          PHASE_ITEMS = 120;

    // One status transaction as seen on the result channel
    typedef struct packed {
        logic              sampled;
        logic [DATA_W-1:0] feedback_position;
        logic [DATA_W-1:0] pwm_duty;
        logic              pwm_enable;
        logic              led_on;
        logic [1:0]        servo_mode;
    } servo_status_t;

    // Tracks the supervisor's registers and state, works out the status each
    // accepted transaction must produce and checks the result stream in order.
    class servo_move_tracker;
        cfg_t              regs;
        mode_t             mode;
        logic [DATA_W-1:0] target_pos;
        logic [DATA_W-1:0] last_target_pos;
        logic [DATA_W-1:0] feedback_pos;
        logic [DATA_W-1:0] hit_count;
        logic [DATA_W-1:0] duty;
        logic [TICK_W-1:0] last_sample_tick;
        logic [TICK_W-1:0] command_tick;
        logic              pwm_on;
        logic              led;
        servo_status_t     status_due[$];
        int                failures;

        function void reset_state();
            regs.adc_start          = ADC_START_RST;
            regs.adc_end            = ADC_END_RST;
            regs.pwm_start          = PWM_START_RST;
            regs.pwm_end            = PWM_END_RST;
            regs.sample_period      = SAMPLE_PERIOD_RST;
            regs.hits_needed        = HITS_NEEDED_RST;
            regs.position_tolerance = POS_TOL_RST;
            regs.move_timeout       = MOVE_TIMEOUT_RST;
            mode             = MODE_READY;
            target_pos       = '0;
            last_target_pos  = '0;
            feedback_pos     = '0;
            hit_count        = '0;
            duty             = '0;
            last_sample_tick = '0;
            command_tick     = '0;
            pwm_on           = 1'b0;
            led              = 1'b0;
            failures         = 0;
            status_due.delete();
        endfunction

        function void write_reg(cfg_idx_t idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_ADC_START:     regs.adc_start          = value;
                CFG_ADC_END:       regs.adc_end            = value;
                CFG_PWM_START:     regs.pwm_start          = value;
                CFG_PWM_END:       regs.pwm_end            = value;
                CFG_SAMPLE_PERIOD: regs.sample_period      = value;
                CFG_HITS_NEEDED:   regs.hits_needed        = value;
                CFG_POS_TOL:       regs.position_tolerance = value;
                CFG_MOVE_TIMEOUT:  regs.move_timeout       = value;
                default: ;
            endcase
        endfunction

        // Raw ADC reading to 0..65535 with clamping; a reversed span counts down
        function logic [DATA_W-1:0] adc_to_canonical(logic [DATA_W-1:0] v);
            int unsigned lo;
            int unsigned hi;
            int unsigned step;
            lo = regs.adc_start;
            hi = regs.adc_end;
            if (lo == hi)
                return CANON_MAX;
            if (hi < lo)
            begin
                step = CANON_MAX / (lo - hi);
                if (v <= hi)
                    return CANON_MAX;
                if (v >= lo)
                    return '0;
                return DATA_W'(CANON_MAX - (v - hi) * step);
            end
            step = CANON_MAX / (hi - lo);
            if (v <= lo)
                return '0;
            if (v >= hi)
                return CANON_MAX;
            return DATA_W'((v - lo) * step);
        endfunction

        // Canonical position to duty, clamped at the far PWM reference
        function logic [DATA_W-1:0] canonical_to_duty(logic [DATA_W-1:0] p);
            int unsigned lo;
            int unsigned hi;
            int unsigned step;
            int unsigned r;
            lo = regs.pwm_start;
            hi = regs.pwm_end;
            if (lo == hi)
                return regs.pwm_end;
            if (hi < lo)
            begin
                step = CANON_MAX / (lo - hi);
                r = (CANON_MAX - p) / step + hi;
                if (r > lo)
                    r = lo;
            end
            else
            begin
                step = CANON_MAX / (hi - lo);
                r = p / step + lo;
                if (r > hi)
                    r = hi;
            end
            return DATA_W'(r);
        endfunction

        function void take_item(logic c, logic [DATA_W-1:0] aim, logic [DATA_W-1:0] adc,
                                logic [TICK_W-1:0] now);
            servo_status_t s;
            int unsigned   dev;
            s.sampled = 1'b0;
            if (c == CMD_SET_TARGET)
            begin
                target_pos = aim;
            end
            else if (now - last_sample_tick >= TICK_W'(regs.sample_period))
            begin
                last_sample_tick = now;
                feedback_pos = adc_to_canonical(adc);
                if (target_pos != last_target_pos)
                begin
                    duty            = canonical_to_duty(target_pos);
                    pwm_on          = 1'b1;
                    led             = 1'b1;
                    last_target_pos = target_pos;
                    hit_count       = '0;
                    command_tick    = now;
                    mode            = MODE_MOVING;
                end
                if (mode == MODE_READY)
                begin
                    duty = '0;
                    led  = 1'b0;
                end
                else if (mode == MODE_MOVING)
                begin
                    dev = (target_pos < feedback_pos) ? feedback_pos - target_pos
                                                      : target_pos - feedback_pos;
                    if (dev <= regs.position_tolerance && hit_count != CANON_MAX)
                        hit_count++;
                    if (hit_count >= regs.hits_needed ||
                        now - command_tick > TICK_W'(regs.move_timeout))
                        mode = MODE_IDLE;
                end
                s.sampled = 1'b1;
            end
            s.feedback_position = feedback_pos;
            s.pwm_duty          = duty;
            s.pwm_enable        = pwm_on;
            s.led_on            = led;
            s.servo_mode        = mode;
            status_due.push_back(s);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                failures++;
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_status(servo_status_t got);
            servo_status_t want;
            if (status_due.size() == 0)
            begin
                failures++;
                $display("%0t: status transaction with nothing expected: %h", $time, got);
                return;
            end
            want = status_due.pop_front();
            compare_field("sampled",           want.sampled,           got.sampled);
            compare_field("feedback_position", want.feedback_position, got.feedback_position);
            compare_field("pwm_duty",          want.pwm_duty,          got.pwm_duty);
            compare_field("pwm_enable",        want.pwm_enable,        got.pwm_enable);
            compare_field("led_on",            want.led_on,            got.led_on);
            compare_field("servo_mode",        want.servo_mode,        got.servo_mode);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    cfg_idx_t          cfg_index;
    logic [DATA_W-1:0] cfg_data;

    spsu_item_if   item_ch ();
    spsu_result_if result_ch ();

    servo_move_tracker tracker;

    // Stimulus controls: idle gaps on both channels, running tick count
    logic              gaps_on;
    logic [TICK_W-1:0] tick_now;
    int                hold_left;
    int unsigned       cycle_count;

    servo_position_move_supervisor_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20-unit clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Gap length: mostly none, often a few cycles, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure; inputs change on the falling edge only
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (gaps_on && $urandom_range(0, 99) < 25)
        begin
            result_ch.ready <= 1'b0;
            hold_left = pick_gap();
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // Every accepted status transaction is checked against the oldest expectation
    always @(posedge clk)
    begin : status_monitor
        servo_status_t seen;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            seen.sampled           = result_ch.sampled;
            seen.feedback_position = result_ch.feedback_position;
            seen.pwm_duty          = result_ch.pwm_duty;
            seen.pwm_enable        = result_ch.pwm_enable;
            seen.led_on            = result_ch.led_on;
            seen.servo_mode        = result_ch.servo_mode;
            tracker.check_status(seen);
        end
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run stopped at the cycle limit", $time);
            $display("servo_position_move_supervisor_unit_test: FAIL");
            $finish;
        end
    end

    // Present one transaction (after an optional gap) and hold it until taken.
    // Called and returns at a falling edge; valid stays high between back-to-back items.
    task automatic send_item(input logic c, input logic [DATA_W-1:0] aim,
                             input logic [DATA_W-1:0] adc, input logic [TICK_W-1:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.cmd             <= c;
        item_ch.target_position <= aim;
        item_ch.adc_sample      <= adc;
        item_ch.now_ticks       <= now;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        tracker.take_item(c, aim, adc, now);
        @(negedge clk);
    endtask

    // Stop sending until every expected status has come back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (tracker.status_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        tracker.write_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic program_regs(input cfg_t c);
        write_reg(CFG_ADC_START,     c.adc_start);
        write_reg(CFG_ADC_END,       c.adc_end);
        write_reg(CFG_PWM_START,     c.pwm_start);
        write_reg(CFG_PWM_END,       c.pwm_end);
        write_reg(CFG_SAMPLE_PERIOD, c.sample_period);
        write_reg(CFG_HITS_NEEDED,   c.hits_needed);
        write_reg(CFG_POS_TOL,       c.position_tolerance);
        write_reg(CFG_MOVE_TIMEOUT,  c.move_timeout);
        cfg_we <= 1'b0;
    endtask

    // Reference pair shapes: forward, reversed, equal, one apart, full scale, anything
    function automatic void pick_refs(input int kind, output logic [DATA_W-1:0] lo_ref,
                                      output logic [DATA_W-1:0] hi_ref);
        logic [DATA_W-1:0] a;
        a = DATA_W'($urandom_range(0, 2000));
        case (kind)
            0:
            begin
                lo_ref = a;
                hi_ref = a + DATA_W'($urandom_range(1, 9000));
            end
            1:
            begin
                hi_ref = a;
                lo_ref = a + DATA_W'($urandom_range(1, 9000));
            end
            2:
            begin
                lo_ref = DATA_W'($urandom);
                hi_ref = lo_ref;
            end
            3:
            begin
                a = DATA_W'($urandom_range(0, CANON_MAX - 1));
                lo_ref = $urandom_range(0, 1) ? a : a + 1'b1;
                hi_ref = (lo_ref == a) ? a + 1'b1 : a;
            end
            4:
            begin
                lo_ref = $urandom_range(0, 1) ? '0 : CANON_MAX;
                hi_ref = ~lo_ref;
            end
            default:
            begin
                lo_ref = DATA_W'($urandom);
                hi_ref = DATA_W'($urandom);
            end
        endcase
    endfunction

    // Register set per phase; the numeric extremes each get a phase of their own
    function automatic cfg_t next_regs(input int phase);
        cfg_t              c;
        logic [DATA_W-1:0] lo_ref;
        logic [DATA_W-1:0] hi_ref;
        pick_refs(phase % 6, lo_ref, hi_ref);
        c.adc_start = lo_ref;
        c.adc_end   = hi_ref;
        pick_refs((phase * 5 + 2) % 6, lo_ref, hi_ref);
        c.pwm_start = lo_ref;
        c.pwm_end   = hi_ref;
        c.sample_period = (phase == 4) ? '0 : (phase == 9) ? CANON_MAX
                        : DATA_W'($urandom_range(0, 40));
        c.hits_needed = (phase == 5) ? DATA_W'(1) : (phase == 10) ? CANON_MAX
                      : DATA_W'($urandom_range(1, 12));
        c.position_tolerance = (phase == 6) ? '0 : (phase == 11) ? CANON_MAX
                             : DATA_W'($urandom_range(0, 6000));
        c.move_timeout = (phase == 7) ? '0 : (phase == 12) ? CANON_MAX
                       : DATA_W'($urandom_range(100, 3000));
        return c;
    endfunction

    // Next sample time: mostly just past the period, some too early,
    // some long jumps that run moves into their timeout, some arbitrary values.
    function automatic logic [TICK_W-1:0] next_tick();
        int unsigned period;
        int          r;
        period = tracker.regs.sample_period;
        r = $urandom_range(0, 99);
        if (r < 75)
            tick_now += period + $urandom_range(0, period / 2 + 20);
        else if (r < 88)
            tick_now += $urandom_range(0, period);
        else if (r < 95)
            tick_now += period + $urandom_range(0, 4000);
        else
            tick_now = $urandom;
        return tick_now;
    endfunction

    // ADC reading aimed near the target so that moves collect hits,
    // with spread inside the calibrated span and some arbitrary readings.
    function automatic logic [DATA_W-1:0] adc_for(input logic [DATA_W-1:0] aim);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned span;
        longint unsigned base;
        int              jit;
        int              v;
        int              r;
        lo = tracker.regs.adc_start;
        hi = tracker.regs.adc_end;
        r  = $urandom_range(0, 99);
        if (r >= 85 || lo == hi)
            return DATA_W'($urandom);
        if (hi > lo)
        begin
            span = hi - lo;
            base = lo + (aim * span) / CANON_MAX;
        end
        else
        begin
            span = lo - hi;
            base = hi + ((CANON_MAX - aim) * span) / CANON_MAX;
        end
        if (r >= 60)
            return DATA_W'($urandom_range(lo < hi ? lo : hi, lo < hi ? hi : lo));
        jit = int'(span / 128) + 1;
        v = int'(base) + $urandom_range(0, 2 * jit) - jit;
        if (v < 0)
            v = 0;
        if (v > CANON_MAX)
            v = CANON_MAX;
        return DATA_W'(v);
    endfunction

    // Moves: a target, then a burst of samples; sometimes the same target
    // again, sometimes a second target before any sample is taken.
    task automatic run_moves(input int count);
        int                sent;
        int                burst;
        int                pause_at;
        int                r;
        logic              paused;
        logic [DATA_W-1:0] aim;
        sent     = 0;
        paused   = 1'b0;
        pause_at = $urandom_range(10, count - 10);
        aim      = tracker.target_pos;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                aim = '0;
            else if (r < 10)
                aim = CANON_MAX;
            else if (r >= 20)
                aim = DATA_W'($urandom);
            send_item(CMD_SET_TARGET, aim, DATA_W'($urandom), $urandom);
            sent++;
            if ($urandom_range(0, 99) < 10)
            begin
                // retarget before the move starts; half the time the same aim again
                if ($urandom_range(0, 1))
                    aim = DATA_W'($urandom);
                send_item(CMD_SET_TARGET, aim, DATA_W'($urandom), $urandom);
                sent++;
            end
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                send_item(CMD_SAMPLE, DATA_W'($urandom), adc_for(aim), next_tick());
                sent++;
                if (!paused && sent >= pause_at)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        int i;
        int phase;
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_ADC_START;
        cfg_data                = '0;
        item_ch.valid           = 1'b0;
        item_ch.cmd             = CMD_SET_TARGET;
        item_ch.target_position = '0;
        item_ch.adc_sample      = '0;
        item_ch.now_ticks       = '0;
        result_ch.ready         = 1'b0;
        gaps_on                 = 1'b1;
        tick_now                = '0;
        hold_left               = 0;
        cycle_count             = 0;
        tracker = new;
        tracker.reset_state();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, with the reset register values (ADC 0..4095, step 16).
        // READY with an unchanged target: duty forced to zero, LED off.
        send_item(CMD_SAMPLE, 16'h1234, 16'd100, 32'd3);      // too soon after reset
        send_item(CMD_SAMPLE, '0, 16'd0, 32'd10);              // exactly one period later
        send_item(CMD_SAMPLE, '1, 16'd4095, 32'd20);           // top of the ADC span
        send_item(CMD_SAMPLE, '0, CANON_MAX, 32'd30);          // beyond the span, clamped
        send_item(CMD_SET_TARGET, '0, '1, '1);                 // same as the last target
        send_item(CMD_SAMPLE, '0, 16'd2048, 32'd40);
        // Move to the top, every sample on target: ends after ten hits
        send_item(CMD_SET_TARGET, CANON_MAX, '0, '0);
        for (i = 0; i < 10; i++)
            send_item(CMD_SAMPLE, DATA_W'($urandom), 16'd4095, TICK_W'(50 + 10 * i));
        send_item(CMD_SAMPLE, '0, 16'd4000, 32'd150);          // idle after the move
        // Move that never reaches its target and times out
        send_item(CMD_SET_TARGET, 16'd1, '0, '0);
        send_item(CMD_SAMPLE, '0, 16'd4095, 32'd1000);
        send_item(CMD_SAMPLE, '0, 16'd4095, 32'd1801);
        // Tick counter wrapping during a move
        send_item(CMD_SET_TARGET, 16'd300, '0, '0);
        send_item(CMD_SAMPLE, '0, 16'd19, 32'hFFFF_FFF8);
        send_item(CMD_SAMPLE, '0, 16'd19, 32'd2);
        send_item(CMD_SAMPLE, '0, 16'd19, 32'd5);              // too soon across the wrap
        tick_now = 32'd5;

        // Random phases, each with its own register set; the last phase of
        // every four runs both channels without idle gaps.
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            program_regs(next_regs(phase));
            gaps_on = (phase % 4 != 3);
            if ($urandom_range(0, 3) == 0)
                tick_now = $urandom;
            run_moves(PHASE_ITEMS);
        end

        drain_results();
        repeat (100) @(posedge clk);
        if (tracker.failures == 0 && tracker.status_due.size() == 0)
            $display("servo_position_move_supervisor_unit_test: PASS");
        else
            $display("servo_position_move_supervisor_unit_test: FAIL");
        $finish;
    end

endmodule
